### sv/svs_pkg.sv
`default_nettype none
package svs_pkg;

  localparam int GRID_SIZE_DEF = 64;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_MOVE   = 2'd2;
  localparam logic [1:0] OP_TRACE  = 2'd3;

  localparam logic [1:0] KIND_SOLID = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [5:0]         cell_col;
    logic [5:0]         cell_row;
    logic signed [31:0] face_u;
    logic signed [31:0] face_v;
    logic [1:0]         cell_kind;
  } svs_in_t;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
  } svs_out_t;

  typedef struct packed {
    logic        start;
    logic [65:0] num;
    logic [32:0] den;
  } svs_div_req_t;

endpackage
`default_nettype wire

### sv/svs_grid_mem.sv
`default_nettype none
module svs_grid_mem #(
  parameter int GRID_SIZE = 64,
  parameter int IDX_W = $clog2(GRID_SIZE * GRID_SIZE)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire logic [IDX_W-1:0]  wr_addr,
  input  wire logic [31:0]       wr_u,
  input  wire logic [31:0]       wr_v,
  input  wire logic [1:0]        wr_kind,
  input  wire logic              rd_en,
  input  wire logic [IDX_W-1:0]  rd_addr,
  output logic [31:0]            rd_u,
  output logic [31:0]            rd_v,
  output logic [1:0]             rd_kind,
  output logic                   ready
);
  localparam int DEPTH = GRID_SIZE * GRID_SIZE;

  logic [31:0] u_mem [DEPTH];
  logic [31:0] v_mem [DEPTH];
  logic [1:0]  k_mem [DEPTH];

  logic [IDX_W-1:0] clr_idx_r;
  logic             clr_r;

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
      clr_r     <= 1'b1;
    end else if (clr_r) begin
      clr_idx_r <= clr_idx_r + IDX_W'(1);
      if (clr_idx_r == IDX_W'(DEPTH - 1)) clr_r <= 1'b0;
    end
  end

  assign ready = !clr_r;

  always_ff @(posedge clk) begin
    if (clr_r) begin
      u_mem[clr_idx_r] <= '0;
      v_mem[clr_idx_r] <= '0;
      k_mem[clr_idx_r] <= '0;
    end else if (wr_en) begin
      u_mem[wr_addr] <= wr_u;
      v_mem[wr_addr] <= wr_v;
      k_mem[wr_addr] <= wr_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_u    <= u_mem[rd_addr];
      rd_v    <= v_mem[rd_addr];
      rd_kind <= k_mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

### sv/svs_div.sv
`default_nettype none
module svs_div (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire svs_pkg::svs_div_req_t req,
  output logic                       done,
  output logic [31:0]                quo
);
  import svs_pkg::*;

  logic        active_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [33:0] rem_r;
  logic [31:0] num_r;
  logic [31:0] q_r;
  logic [32:0] den_r;

  logic [33:0] rem2;
  logic        ge;

  assign rem2 = {rem_r[32:0], num_r[31]};
  assign ge   = rem2 >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        active_r <= 1'b1;
        cnt_r    <= 6'd32;
      end else if (active_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  // quotient fits 32 bits, so the high numerator part starts below den
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.num[65:32];
      num_r <= req.num[31:0];
      den_r <= req.den;
      q_r   <= '0;
    end else if (active_r) begin
      rem_r <= ge ? (rem2 - {1'b0, den_r}) : rem2;
      num_r <= {num_r[30:0], 1'b0};
      q_r   <= {q_r[30:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = q_r;
endmodule
`default_nettype wire

### sv/staggered_grid_velocity_sampler.sv
`default_nettype none
// Staggered-grid velocity sampler.
// Input channel: an item (in_item) is taken when start is high and busy low.
// Opcode write stores one cell in the accept cycle and gives no result.
// Opcodes sample, move and trace give one result: out_strobe is high for
// exactly one cycle with out_item; the receiver cannot stall it.
// Config: cfg_we with cfg_wdata writes step_time (unsigned Q15.16); the
// user must write it only when idle; the block itself does not enforce it.
// One velocity sample runs two components; each takes four corners through
// the read, multiply and accumulate states on the shared multiplier, then
// a 32-step divide, skipped if the weights of the used corners (not solid,
// in the grid) sum to zero. Busy stays high for the whole item; the next
// item can be taken in the cycle after the strobe. After reset the grid
// memory is cleared with busy high; config writes are taken during that pass.
module staggered_grid_velocity_sampler #(
  parameter int GRID_SIZE = svs_pkg::GRID_SIZE_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire svs_pkg::svs_in_t in_item,
  output logic                  out_strobe,
  output svs_pkg::svs_out_t     out_item,
  input  wire logic             cfg_we,
  input  wire logic [30:0]      cfg_wdata
);
  import svs_pkg::*;

  localparam int IDX_W = $clog2(GRID_SIZE * GRID_SIZE);
  localparam int CW    = $clog2(GRID_SIZE);

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_RD   = 4'd2;
  localparam logic [3:0] ST_MUL  = 4'd3;
  localparam logic [3:0] ST_ACC  = 4'd4;
  localparam logic [3:0] ST_DIVS = 4'd5;
  localparam logic [3:0] ST_DIVW = 4'd6;
  localparam logic [3:0] ST_MX   = 4'd7;
  localparam logic [3:0] ST_AX   = 4'd8;
  localparam logic [3:0] ST_MY   = 4'd9;
  localparam logic [3:0] ST_AY   = 4'd10;
  localparam logic [3:0] ST_OUT  = 4'd11;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] a);
    if (a > 68'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (a < -68'sh80000000) return 32'sh80000000;
    return a[31:0];
  endfunction

  logic [3:0]  state_r, state_nxt;
  logic [30:0] step_r;
  logic [1:0]  op_r, ph_r, corner_r;
  logic        comp_r;
  logic signed [31:0] px_r, py_r, qx_r, qy_r, vx_r, vy_r, nx_r, ny_r;
  logic [32:0] w_r;
  logic        ok_r, use_r;
  logic signed [66:0] prod_r, sum_r;
  logic [33:0] wsum_r;

  logic mem_ready;
  logic [31:0] rd_u, rd_v;
  logic [1:0]  rd_kind;
  logic        wr_en, rd_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  // write port
  assign wr_en = accept && (in_item.opcode == OP_WRITE) &&
                 (32'(in_item.cell_col) < GRID_SIZE) && (32'(in_item.cell_row) < GRID_SIZE);
  assign wr_addr = IDX_W'(in_item.cell_row) * IDX_W'(GRID_SIZE) + IDX_W'(in_item.cell_col);

  // corner geometry
  logic signed [32:0] cx, cy;
  logic signed [17:0] cc, cr;
  logic [16:0] wx, wy;
  logic        in_grid;
  assign cx = comp_r ? (33'(qx_r) - 33'sd32768) : 33'(qx_r);
  assign cy = comp_r ? 33'(qy_r) : (33'(qy_r) - 33'sd32768);
  assign cc = 18'(signed'(cx[32:16])) + 18'(corner_r[0]);
  assign cr = 18'(signed'(cy[32:16])) + 18'(corner_r[1]);
  assign wx = corner_r[0] ? {1'b0, cx[15:0]} : (17'h10000 - {1'b0, cx[15:0]});
  assign wy = corner_r[1] ? {1'b0, cy[15:0]} : (17'h10000 - {1'b0, cy[15:0]});
  assign in_grid = (cc >= 0) && (cc < 18'sd0 + 18'(GRID_SIZE)) &&
                   (cr >= 0) && (cr < 18'sd0 + 18'(GRID_SIZE));
  assign rd_en   = (state_r == ST_RD);
  assign rd_addr = IDX_W'(cr[CW-1:0]) * IDX_W'(GRID_SIZE) + IDX_W'(cc[CW-1:0]);

  svs_grid_mem #(.GRID_SIZE(GRID_SIZE), .IDX_W(IDX_W)) u_mem (
    .clk, .rst_n,
    .wr_en, .wr_addr, .wr_u(in_item.face_u), .wr_v(in_item.face_v),
    .wr_kind(in_item.cell_kind),
    .rd_en, .rd_addr, .rd_u, .rd_v, .rd_kind, .ready(mem_ready)
  );

  // shared multiplier
  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [66:0] prod;
  always_comb begin
    case (state_r)
      ST_RD: begin
        mul_a = {17'd0, wx};
        mul_b = {16'd0, wy};
      end
      ST_MUL: begin
        mul_a = {1'b0, w_r};
        mul_b = 33'(signed'(comp_r ? rd_v : rd_u));
      end
      ST_MX: begin
        mul_a = 34'(vx_r);
        mul_b = {2'b0, step_r};
      end
      ST_MY: begin
        mul_a = 34'(vy_r);
        mul_b = {2'b0, step_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod = 67'(mul_a) * 67'(mul_b);

  // divider
  svs_div_req_t div_req;
  logic         div_done;
  logic [31:0]  div_quo;
  logic         neg;
  logic [66:0]  mag;
  assign neg = sum_r[66];
  assign mag = neg ? 67'(-sum_r) : 67'(sum_r);
  assign div_req.start = (state_r == ST_DIVS) && (wsum_r != '0);
  assign div_req.num   = mag[65:0];
  assign div_req.den   = wsum_r[32:0];

  svs_div u_div (.clk, .rst_n, .req(div_req), .done(div_done), .quo(div_quo));

  logic        fin;
  logic signed [31:0] fin_val;
  logic signed [67:0] qs;
  assign qs = neg ? -68'(div_quo) : 68'(div_quo);
  assign fin = ((state_r == ST_DIVS) && (wsum_r == '0)) || ((state_r == ST_DIVW) && div_done);
  assign fin_val = (wsum_r == '0) ? 32'sd0 : sat32(qs);

  // displacement step
  logic signed [66:0] r17, r16, disp;
  logic signed [67:0] base, moved;
  logic signed [31:0] new_c;
  assign r17  = (prod_r + 67'sd65536) >>> 17;
  assign r16  = (prod_r + 67'sd32768) >>> 16;
  assign disp = (ph_r == 2'd0) ? r17 : r16;
  assign base = 68'((state_r == ST_AX) ? px_r : py_r);
  assign moved = (op_r == OP_MOVE) ? (base + 68'(disp)) : (base - 68'(disp));
  assign new_c = sat32(moved);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR:  if (mem_ready) state_nxt = ST_IDLE;
      ST_IDLE: if (accept && in_item.opcode != OP_WRITE) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_ACC;
      ST_ACC:  state_nxt = (corner_r == 2'd3) ? ST_DIVS : ST_RD;
      ST_DIVS, ST_DIVW: begin
        if (state_r == ST_DIVS) state_nxt = ST_DIVW;
        if (fin) begin
          if (!comp_r) state_nxt = ST_RD;
          else if (op_r == OP_SAMPLE || ph_r == 2'd2) state_nxt = ST_OUT;
          else state_nxt = ST_MX;
        end
      end
      ST_MX:   state_nxt = ST_AX;
      ST_AX:   state_nxt = ST_MY;
      ST_MY:   state_nxt = ST_AY;
      ST_AY:   state_nxt = (ph_r == 2'd0 || op_r == OP_TRACE) ? ST_RD : ST_OUT;
      ST_OUT:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) step_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        op_r     <= in_item.opcode;
        px_r     <= in_item.pos_x;
        py_r     <= in_item.pos_y;
        qx_r     <= in_item.pos_x;
        qy_r     <= in_item.pos_y;
        ph_r     <= 2'd0;
        comp_r   <= 1'b0;
        corner_r <= 2'd0;
        sum_r    <= '0;
        wsum_r   <= '0;
      end
      ST_RD: begin
        w_r  <= prod[32:0];
        ok_r <= in_grid;
      end
      ST_MUL: begin
        prod_r <= prod;
        use_r  <= ok_r && (rd_kind != KIND_SOLID);
      end
      ST_ACC: begin
        if (use_r) begin
          sum_r  <= sum_r + prod_r;
          wsum_r <= wsum_r + 34'(w_r);
        end
        corner_r <= corner_r + 2'd1;
      end
      ST_DIVS, ST_DIVW: begin
        if (fin) begin
          if (!comp_r) vx_r <= fin_val;
          else vy_r <= fin_val;
          comp_r   <= ~comp_r;
          corner_r <= 2'd0;
          sum_r    <= '0;
          wsum_r   <= '0;
          if (comp_r && op_r == OP_SAMPLE) begin
            nx_r <= px_r;
            ny_r <= py_r;
          end
        end
      end
      ST_MX, ST_MY: prod_r <= prod;
      ST_AX: begin
        qx_r <= new_c;
        if (ph_r != 2'd0) nx_r <= new_c;
      end
      ST_AY: begin
        qy_r <= new_c;
        if (ph_r != 2'd0) ny_r <= new_c;
        ph_r <= ph_r + 2'd1;
      end
      default: ;
    endcase
  end

  assign out_strobe     = (state_r == ST_OUT);
  assign out_item.vel_x = vx_r;
  assign out_item.vel_y = vy_r;
  assign out_item.new_x = nx_r;
  assign out_item.new_y = ny_r;

`ifndef SYNTHESIS
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy) else $error("result strobe while idle");
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("result strobe longer than one cycle");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.opcode != OP_WRITE) |=> busy) else $error("item not started");
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIVW)) else $error("divide finished unexpectedly");
`endif
endmodule
`default_nettype wire

### tb/testbench.sv
`default_nettype none
module testbench;
  import svs_pkg::*;

  localparam int GS = 64;
  localparam longint ONE = 65536;
  localparam longint HALF = 32768;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  svs_in_t in_item;
  logic out_strobe;
  svs_out_t out_item;
  logic cfg_we;
  logic [30:0] cfg_wdata;

  staggered_grid_velocity_sampler u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  logic signed [31:0] u_grid [0:GS*GS-1];
  logic signed [31:0] v_grid [0:GS*GS-1];
  logic [1:0] kind_grid [0:GS*GS-1];
  longint step_t;

  svs_in_t pending_items[$];
  svs_out_t expected_vel[$];
  int sender_idle_pct;
  int errors;

  function automatic void add_item(input svs_in_t it);
    pending_items = {pending_items, it};
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic longint sat32(longint a);
    if (a > 64'sd2147483647) return 64'sd2147483647;
    if (a < -64'sd2147483648) return -64'sd2147483648;
    return a;
  endfunction

  function automatic longint round_sh(longint a, int s);
    return (a + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint blend_face(bit use_v, longint x, longint y);
    longint fx, fy, ci, cj, c, r, w, acc, wsum, val;
    int idx;
    fx = x & 64'hFFFF;
    fy = y & 64'hFFFF;
    ci = (x - fx) >>> 16;
    cj = (y - fy) >>> 16;
    acc = 0;
    wsum = 0;
    for (int dy = 0; dy < 2; dy++) begin
      for (int dx = 0; dx < 2; dx++) begin
        c = ci + dx;
        r = cj + dy;
        if (c < 0 || c >= GS || r < 0 || r >= GS) continue;
        idx = int'(r * GS + c);
        if (kind_grid[idx] == KIND_SOLID) continue;
        w = (dx ? fx : ONE - fx) * (dy ? fy : ONE - fy);
        val = use_v ? longint'(v_grid[idx]) : longint'(u_grid[idx]);
        acc += w * val;
        wsum += w;
      end
    end
    if (wsum == 0) return 0;
    return acc / wsum;
  endfunction

  task automatic vel_at(input longint x, input longint y, output longint vx,
                        output longint vy);
    vx = blend_face(1'b0, x, y - HALF);
    vy = blend_face(1'b1, x - HALF, y);
  endtask

  task automatic predict_item(input svs_in_t it);
    longint px, py, vx, vy, mx, my, nx, ny;
    svs_out_t res;
    int idx;
    px = it.pos_x;
    py = it.pos_y;
    if (it.opcode == OP_WRITE) begin
      idx = int'(it.cell_row) * GS + int'(it.cell_col);
      u_grid[idx] = it.face_u;
      v_grid[idx] = it.face_v;
      kind_grid[idx] = it.cell_kind;
      return;
    end
    vel_at(px, py, vx, vy);
    nx = px;
    ny = py;
    if (it.opcode == OP_MOVE) begin
      mx = sat32(px + round_sh(vx * step_t, 17));
      my = sat32(py + round_sh(vy * step_t, 17));
      vel_at(mx, my, vx, vy);
      nx = sat32(px + round_sh(vx * step_t, 16));
      ny = sat32(py + round_sh(vy * step_t, 16));
    end else if (it.opcode == OP_TRACE) begin
      mx = sat32(px - round_sh(vx * step_t, 17));
      my = sat32(py - round_sh(vy * step_t, 17));
      vel_at(mx, my, vx, vy);
      nx = sat32(px - round_sh(vx * step_t, 16));
      ny = sat32(py - round_sh(vy * step_t, 16));
      vel_at(nx, ny, vx, vy);
    end
    res.vel_x = 32'(sat32(vx));
    res.vel_y = 32'(sat32(vy));
    res.new_x = 32'(nx);
    res.new_y = 32'(ny);
    expected_vel = {expected_vel, res};
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) predict_item(in_item);
      if (!start || !busy) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          start <= 1'b1;
          in_item <= pending_items.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    svs_out_t want;
    if (rst_n && out_strobe) begin
      if (expected_vel.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", out_item);
      end else begin
        want = expected_vel.pop_front();
        if (want.vel_x !== out_item.vel_x || want.vel_y !== out_item.vel_y ||
            want.new_x !== out_item.new_x || want.new_y !== out_item.new_y) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp vx=%h vy=%h nx=%h ny=%h got vx=%h vy=%h nx=%h ny=%h",
                     want.vel_x, want.vel_y, want.new_x, want.new_y, out_item.vel_x,
                     out_item.vel_y, out_item.new_x, out_item.new_y);
        end
      end
    end
  end

  function automatic int rnd_pos();
    int r;
    r = $urandom_range(99);
    if (r < 70) return int'($urandom_range(0, 8 * 65536));
    if (r < 85) return 56 * 65536 + int'($urandom_range(0, 9 * 65536));
    if (r < 92) return -int'($urandom_range(0, 3 * 65536));
    return int'($urandom);
  endfunction

  function automatic logic [5:0] rnd_cell();
    if ($urandom_range(99) < 80) return 6'($urandom_range(0, 8));
    return 6'($urandom_range(0, 63));
  endfunction

  function automatic int rnd_face();
    if ($urandom_range(99) < 75) return int'($urandom_range(0, 8 * 65536)) - 4 * 65536;
    return int'($urandom);
  endfunction

  function automatic svs_in_t mk_item(logic [1:0] op, int px, int py, int col, int row,
                                      int fu, int fv, int kind);
    svs_in_t it;
    it.opcode = op;
    it.pos_x = px;
    it.pos_y = py;
    it.cell_col = 6'(col);
    it.cell_row = 6'(row);
    it.face_u = fu;
    it.face_v = fv;
    it.cell_kind = 2'(kind);
    return it;
  endfunction

  task automatic set_step(input logic [30:0] v);
    wait (pending_items.size() == 0 && !start && expected_vel.size() == 0);
    repeat (400) @(posedge clk);
    wait (!busy);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    step_t = longint'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [30:0] steps [5];
    int idle_modes [5];
    int r;
    logic [1:0] op;
    rst_n = 1'b0;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_item = '0;
    errors = 0;
    step_t = 0;
    sender_idle_pct = 0;
    for (int k = 0; k < GS * GS; k++) begin
      u_grid[k] = 0;
      v_grid[k] = 0;
      kind_grid[k] = 0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed, step_time still zero
    add_item(mk_item(OP_SAMPLE, 65536, 65536, 0, 0, 0, 0, 0));
    add_item(mk_item(OP_MOVE, 98304, 98304, 0, 0, 0, 0, 0));
    set_step(31'h10000);
    add_item(mk_item(OP_WRITE, 0, 0, 0, 0, 65536, -65536, 0));
    add_item(mk_item(OP_WRITE, 0, 0, 1, 0, 2 * 65536, 32768, 1));
    add_item(mk_item(OP_WRITE, 0, 0, 0, 1, -3 * 65536, 65536, 3));
    add_item(mk_item(OP_WRITE, 0, 0, 1, 1, 7 * 65536, 7 * 65536, 2));
    add_item(mk_item(OP_WRITE, 0, 0, 63, 63, 32'sh7FFFFFFF,
                     32'sh80000000, 0));
    add_item(mk_item(OP_WRITE, 0, 0, 62, 63, 32'sh80000000,
                     32'sh7FFFFFFF, 1));
    add_item(mk_item(OP_SAMPLE, 40000, 70000, 0, 0, 0, 0, 0));
    add_item(mk_item(OP_SAMPLE, 65536 + 32768, 65536 + 32768, 0, 0, 0, 0, 0));
    add_item(mk_item(OP_SAMPLE, -5 * 65536, -5 * 65536, 0, 0, 0, 0, 0));
    add_item(mk_item(OP_SAMPLE, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 63, 63,
                     -1, -1, 3));
    add_item(mk_item(OP_SAMPLE, 32'sh80000000, 32'sh80000000, 0, 0, 0, 0, 0));
    add_item(mk_item(OP_SAMPLE, 63 * 65536 + 40000, 63 * 65536 + 40000,
                     0, 0, 0, 0, 0));
    add_item(mk_item(OP_MOVE, 50000, 50000, 0, 0, 0, 0, 0));
    add_item(mk_item(OP_TRACE, 50000, 80000, 0, 0, 0, 0, 0));
    add_item(mk_item(OP_MOVE, 63 * 65536, 63 * 65536, 0, 0, 0, 0, 0));
    add_item(mk_item(OP_TRACE, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0, 0, 0));
    set_step(31'h7FFFFFFF);
    add_item(mk_item(OP_MOVE, 63 * 65536 + 20000, 63 * 65536 + 50000,
                     0, 0, 0, 0, 0));
    add_item(mk_item(OP_TRACE, 63 * 65536 + 20000, 63 * 65536 + 50000,
                     0, 0, 0, 0, 0));
    add_item(mk_item(OP_MOVE, 50000, 50000, 0, 0, 0, 0, 0));

    steps[0] = 31'h8000;
    steps[1] = 31'h7FFFFFFF;
    steps[2] = 31'h0;
    steps[3] = 31'($urandom);
    steps[4] = 31'h10000;
    idle_modes[0] = 0;
    idle_modes[1] = 87;
    idle_modes[2] = 0;
    idle_modes[3] = 34;
    idle_modes[4] = 87;
    for (int ph = 0; ph < 5; ph++) begin
      set_step(steps[ph]);
      sender_idle_pct = idle_modes[ph];
      for (int n = 0; n < 326; n++) begin
        r = $urandom_range(99);
        op = r < 30 ? OP_WRITE : r < 55 ? OP_SAMPLE : r < 78 ? OP_MOVE : OP_TRACE;
        add_item(mk_item(op, rnd_pos(), rnd_pos(), rnd_cell(), rnd_cell(),
                         rnd_face(), rnd_face(), $urandom_range(0, 3)));
      end
    end

    wait (pending_items.size() == 0 && !start && expected_vel.size() == 0);
    repeat (400) @(posedge clk);
    if (errors == 0 && expected_vel.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

endmodule
`default_nettype wire
